FILE: src/assert_macros.svh
// Assertion helpers. Each macro expects clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset.
`define BSIM_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BSIM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define BSIM_ASSERT_ALWAYS(label, expr, msg)
`define BSIM_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

FILE: src/bsim_pkg.sv
package bsim_pkg;

  localparam int unsigned ADDR_W    = 16;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned MIRROR_W  = 2;
  localparam int unsigned CHR_SLOTS = 8;
  localparam int unsigned PRG_SLOTS = 3;
  localparam int unsigned CHR_W     = CHR_SLOTS * BYTE_W;
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned CFG_DAT_W = 8;
  localparam int unsigned PRESC_W   = 10;

  typedef enum logic {
    ACT_WRITE = 1'b0,
    ACT_TICK  = 1'b1
  } action_t;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LAST_PRG   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHR_IS_ROM = 8'd1;

  localparam logic [BYTE_W-1:0] LAST_PRG_RESET = 8'hFF;

  // CPU write map
  localparam logic [ADDR_W-1:0] ADDR_PRG0   = 16'h8000;
  localparam logic [ADDR_W-1:0] ADDR_PRG1_A = 16'h8008;
  localparam logic [ADDR_W-1:0] ADDR_PRG1_B = 16'h8010;
  localparam logic [ADDR_W-1:0] ADDR_PRG2   = 16'h9000;
  localparam logic [ADDR_W-1:0] ADDR_CHR0   = 16'hA000;
  localparam logic [ADDR_W-1:0] ADDR_CHR1_A = 16'hA008;
  localparam logic [ADDR_W-1:0] ADDR_CHR1_B = 16'hA010;
  localparam logic [ADDR_W-1:0] ADDR_CHR2   = 16'hB000;
  localparam logic [ADDR_W-1:0] ADDR_CHR3_A = 16'hB008;
  localparam logic [ADDR_W-1:0] ADDR_CHR3_B = 16'hB010;
  localparam logic [ADDR_W-1:0] ADDR_CHR4   = 16'hC000;
  localparam logic [ADDR_W-1:0] ADDR_CHR5_A = 16'hC008;
  localparam logic [ADDR_W-1:0] ADDR_CHR5_B = 16'hC010;
  localparam logic [ADDR_W-1:0] ADDR_CHR6   = 16'hD000;
  localparam logic [ADDR_W-1:0] ADDR_CHR7_A = 16'hD008;
  localparam logic [ADDR_W-1:0] ADDR_CHR7_B = 16'hD010;
  localparam logic [ADDR_W-1:0] ADDR_MIRROR = 16'hE000;
  localparam logic [ADDR_W-1:0] ADDR_RELD_A = 16'hE008;
  localparam logic [ADDR_W-1:0] ADDR_RELD_B = 16'hE010;
  localparam logic [ADDR_W-1:0] ADDR_IRQ_CTL = 16'hF000;
  localparam logic [ADDR_W-1:0] ADDR_IRQ_ACK_A = 16'hF008;
  localparam logic [ADDR_W-1:0] ADDR_IRQ_ACK_B = 16'hF010;

  // IRQ control byte bits
  localparam int unsigned CTL_AFTER_ACK_BIT = 0;
  localparam int unsigned CTL_ENABLE_BIT    = 1;
  localparam int unsigned CTL_CYCLE_BIT     = 2;

  localparam logic [BYTE_W-1:0] COUNT_FIRE = 8'hFF;

  localparam logic signed [PRESC_W-1:0] PRESCALE_TOP  = 10'sd341;
  localparam logic signed [PRESC_W-1:0] PRESCALE_STEP = 10'sd3;
  localparam logic signed [PRESC_W-1:0] PRESCALE_MIN  = -10'sd2;

endpackage

FILE: src/bsim_ifs.sv
interface bsim_in_if import bsim_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              action;
  logic [ADDR_W-1:0] address;
  logic [BYTE_W-1:0] value;

  modport source (output valid, action, address, value, input ready);
  modport sink   (input valid, action, address, value, output ready);
endinterface

interface bsim_out_if import bsim_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                irq_line;
  logic [MIRROR_W-1:0] mirroring;
  logic [BYTE_W-1:0]   prg_bank_low;
  logic [BYTE_W-1:0]   prg_bank_mid;
  logic [BYTE_W-1:0]   prg_bank_high;
  logic [CHR_W-1:0]    chr_banks;
  logic [BYTE_W-1:0]   irq_count_now;

  modport source (output valid, irq_line, mirroring, prg_bank_low, prg_bank_mid,
                  prg_bank_high, chr_banks, irq_count_now, input ready);
  modport sink   (input valid, irq_line, mirroring, prg_bank_low, prg_bank_mid,
                  prg_bank_high, chr_banks, irq_count_now, output ready);
endinterface

interface bsim_cfg_if import bsim_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: src/bank_switch_irq_mapper_top.sv
// Channel   Role    Payload
// -------   -----   -----------------------------------------------------------
// in_ch     sink    action, address[15:0], value[7:0]
// out_ch    source  irq_line, mirroring, prg_bank_low/mid/high, chr_banks,
//                   irq_count_now
// cfg_ch    sink    index[7:0], data[7:0]
//
// One request per clock while the output is drained: every accepted request updates the bank and IRQ
// state in the same edge and loads one result into the output register, so
// the result shows in the cycle after acceptance.
// The output register is the only buffer: in_ch.ready is high while that
// register is empty or being drained, so a stalled consumer stalls the input.
// rst is synchronous, active high; no clearing pass, the block accepts work
// in the first cycle after reset. cfg_ch is always ready.

`include "assert_macros.svh"

module bank_switch_irq_mapper_top import bsim_pkg::*; (
  input logic        clk,
  input logic        rst,
  bsim_in_if.sink    in_ch,
  bsim_out_if.source out_ch,
  bsim_cfg_if.sink   cfg_ch
);

  // Held configuration; the fixed E000 bank and ROM/RAM flag are kept for
  // the board but do not shape the reported result.
  logic [BYTE_W-1:0] last_prg_bank;
  logic              chr_is_rom;

  // Mapper state
  logic [BYTE_W-1:0]   prg_regs [PRG_SLOTS];
  logic [BYTE_W-1:0]   chr_regs [CHR_SLOTS];
  logic [MIRROR_W-1:0] mirror_mode;
  logic [BYTE_W-1:0]   reload_value;
  logic [BYTE_W-1:0]   irq_count;
  logic signed [PRESC_W-1:0] prescale;
  logic cycle_mode;
  logic irq_on;
  logic irq_on_after_ack;
  logic irq_pending;

  logic [BYTE_W-1:0]   prg_regs_next [PRG_SLOTS];
  logic [BYTE_W-1:0]   chr_regs_next [CHR_SLOTS];
  logic [MIRROR_W-1:0] mirror_mode_next;
  logic [BYTE_W-1:0]   reload_value_next;
  logic [BYTE_W-1:0]   irq_count_next;
  logic signed [PRESC_W-1:0] prescale_next;
  logic cycle_mode_next;
  logic irq_on_next;
  logic irq_on_after_ack_next;
  logic irq_pending_next;

  logic              clock_count;
  logic [BYTE_W-1:0] count_inc;
  logic [CHR_W-1:0]  chr_packed_next;

  logic in_accept;
  logic out_valid;

  // Accept a new request whenever the result register is free this edge.
  assign in_ch.ready = !out_valid || out_ch.ready;
  assign in_accept   = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  // Configuration writes; indexes beyond the list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      last_prg_bank <= LAST_PRG_RESET;
      chr_is_rom    <= 1'b1;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      if (cfg_ch.index == CFG_LAST_PRG) begin
        last_prg_bank <= cfg_ch.data;
      end else if (cfg_ch.index == CFG_CHR_IS_ROM) begin
        chr_is_rom <= cfg_ch.data[0];
      end
    end
  end

  // Next state for one request: either a register write or one tick.
  always_comb begin
    prg_regs_next         = prg_regs;
    chr_regs_next         = chr_regs;
    mirror_mode_next      = mirror_mode;
    reload_value_next     = reload_value;
    prescale_next         = prescale;
    cycle_mode_next       = cycle_mode;
    irq_on_next           = irq_on;
    irq_on_after_ack_next = irq_on_after_ack;
    irq_pending_next      = irq_pending;
    irq_count_next        = irq_count;
    clock_count           = 1'b0;
    count_inc             = irq_count + 8'd1;

    if (in_ch.action == ACT_TICK) begin
      // Prescaler holds while the IRQ unit is off.
      if (irq_on) begin
        if (cycle_mode) begin
          clock_count = 1'b1;
        end else if (prescale > 10'sd0) begin
          prescale_next = prescale - PRESCALE_STEP;
        end else begin
          prescale_next = prescale + PRESCALE_TOP;
          clock_count   = 1'b1;
        end
      end
      // Fire one count early: reaching 0xFF raises IRQ and reloads at once.
      if (clock_count) begin
        if (count_inc == COUNT_FIRE) begin
          irq_pending_next = 1'b1;
          irq_count_next   = reload_value;
        end else begin
          irq_count_next = count_inc;
        end
      end
    end else begin
      unique case (in_ch.address)
        ADDR_PRG0:                  prg_regs_next[0] = in_ch.value;
        ADDR_PRG1_A, ADDR_PRG1_B:   prg_regs_next[1] = in_ch.value;
        ADDR_PRG2:                  prg_regs_next[2] = in_ch.value;
        ADDR_CHR0:                  chr_regs_next[0] = in_ch.value;
        ADDR_CHR1_A, ADDR_CHR1_B:   chr_regs_next[1] = in_ch.value;
        ADDR_CHR2:                  chr_regs_next[2] = in_ch.value;
        ADDR_CHR3_A, ADDR_CHR3_B:   chr_regs_next[3] = in_ch.value;
        ADDR_CHR4:                  chr_regs_next[4] = in_ch.value;
        ADDR_CHR5_A, ADDR_CHR5_B:   chr_regs_next[5] = in_ch.value;
        ADDR_CHR6:                  chr_regs_next[6] = in_ch.value;
        ADDR_CHR7_A, ADDR_CHR7_B:   chr_regs_next[7] = in_ch.value;
        ADDR_MIRROR:                mirror_mode_next = in_ch.value[MIRROR_W-1:0];
        ADDR_RELD_A, ADDR_RELD_B:   reload_value_next = in_ch.value;
        ADDR_IRQ_CTL: begin
          cycle_mode_next       = in_ch.value[CTL_CYCLE_BIT];
          irq_on_next           = in_ch.value[CTL_ENABLE_BIT];
          irq_on_after_ack_next = in_ch.value[CTL_AFTER_ACK_BIT];
          // Enabling restarts the counter from the reload value.
          if (in_ch.value[CTL_ENABLE_BIT]) begin
            irq_count_next = reload_value;
            prescale_next  = PRESCALE_TOP;
          end
          irq_pending_next = 1'b0;
        end
        ADDR_IRQ_ACK_A, ADDR_IRQ_ACK_B: begin
          irq_pending_next = 1'b0;
          irq_on_next      = irq_on_after_ack;
        end
        default: begin
          // Unmapped address: drop the write.
        end
      endcase
    end

    for (int i = 0; i < CHR_SLOTS; i++) begin
      chr_packed_next[i*BYTE_W +: BYTE_W] = chr_regs_next[i];
    end
  end

  // State advances only on an accepted request.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PRG_SLOTS; i++) begin
        prg_regs[i] <= '0;
      end
      for (int i = 0; i < CHR_SLOTS; i++) begin
        chr_regs[i] <= '0;
      end
      mirror_mode      <= '0;
      reload_value     <= '0;
      irq_count        <= '0;
      prescale         <= PRESCALE_TOP;
      cycle_mode       <= 1'b0;
      irq_on           <= 1'b0;
      irq_on_after_ack <= 1'b0;
      irq_pending      <= 1'b0;
    end else if (in_accept) begin
      prg_regs         <= prg_regs_next;
      chr_regs         <= chr_regs_next;
      mirror_mode      <= mirror_mode_next;
      reload_value     <= reload_value_next;
      irq_count        <= irq_count_next;
      prescale         <= prescale_next;
      cycle_mode       <= cycle_mode_next;
      irq_on           <= irq_on_next;
      irq_on_after_ack <= irq_on_after_ack_next;
      irq_pending      <= irq_pending_next;
    end
  end

  // Result register: valid is control, payload loads on accept only.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_ch.irq_line      <= irq_pending_next;
      out_ch.mirroring     <= mirror_mode_next;
      out_ch.prg_bank_low  <= prg_regs_next[0];
      out_ch.prg_bank_mid  <= prg_regs_next[1];
      out_ch.prg_bank_high <= prg_regs_next[2];
      out_ch.chr_banks     <= chr_packed_next;
      out_ch.irq_count_now <= irq_count_next;
    end
  end

  assign out_ch.valid = out_valid;

  // The shown result always reflects the live state it was taken from.
  `BSIM_ASSERT_ALWAYS(a_count_matches, !out_valid || (out_ch.irq_count_now == irq_count && out_ch.irq_line == irq_pending), "result out of step with IRQ state")
  `BSIM_ASSERT_ALWAYS(a_prescale_range, prescale >= PRESCALE_MIN && prescale <= PRESCALE_TOP, "prescaler out of range")
  `BSIM_ASSERT_NEXT(a_tick_off_holds, in_accept && in_ch.action == ACT_TICK && !irq_on, $stable(irq_count) && $stable(prescale), "disabled tick moved the counter")
  `BSIM_ASSERT_NEXT(a_ack_clears, in_accept && in_ch.action == ACT_WRITE && (in_ch.address == ADDR_IRQ_CTL || in_ch.address == ADDR_IRQ_ACK_A || in_ch.address == ADDR_IRQ_ACK_B), !irq_pending, "acknowledge left IRQ pending")
  `BSIM_ASSERT_NEXT(a_cfg_kept, cfg_ch.valid && cfg_ch.index == CFG_CHR_IS_ROM, chr_is_rom == $past(cfg_ch.data[0]) && $stable(last_prg_bank), "config write misrouted")

endmodule
